### sv/cipa_pkg.sv
// Package: constants and types for the interrupt priority arbiter.
`default_nettype none
package cipa_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXT_MASK    = 3'd0,
        CFG_PRIORITY_A  = 3'd1,
        CFG_TIMER_PRI   = 3'd2,
        CFG_DIV_VEC     = 3'd3,
        CFG_WDT_VEC     = 3'd4,
        CFG_TIMER_VEC_C = 3'd5,
        CFG_TIMER_VEC_D = 3'd6,
        CFG_DMA_VECS    = 3'd7
    } cfg_idx_t;

    localparam int LVL_W = 4;
    localparam int VEC_W = 7;

    typedef logic [LVL_W-1:0] lvl_t;
    typedef logic [VEC_W-1:0] vec_t;

    // Fixed external levels and vectors (vector = 64 + level/2)
    localparam lvl_t EXT_LVL_NMI = 4'd14;
    localparam lvl_t EXT_LVL_3   = 4'd12;
    localparam lvl_t EXT_LVL_2   = 4'd10;
    localparam lvl_t EXT_LVL_1   = 4'd8;
    localparam lvl_t EXT_LVL_0   = 4'd6;
    localparam vec_t EXT_VEC_BASE = 7'd64;

    // Watchdog request pattern on bits 7:5
    localparam logic [2:0] WDT_REQ_PAT = 3'b101;

    // Timer flag positions
    localparam int TMR_CAP_BIT  = 7;
    localparam int TMR_CMPA_BIT = 3;
    localparam int TMR_CMPB_BIT = 2;
    localparam int TMR_OVF_BIT  = 1;

    // One registered input item
    typedef struct packed {
        logic [4:0] external_pending;
        logic [1:0] divider_ctrl;
        logic [2:0] dma0_chan_ctrl;
        logic [2:0] dma1_chan_ctrl;
        logic [7:0] watchdog_status;
        logic [7:0] timer_status;
        logic [7:0] timer_enables;
    } in_item_t;

    // Current winner of the priority chain
    typedef struct packed {
        lvl_t lvl;
        vec_t vec;
    } winner_t;

    // A requesting source replaces the winner only at a strictly higher level
    function automatic winner_t offer(input winner_t cur, input logic req,
                                      input lvl_t lvl, input vec_t vec);
        winner_t res;
        res = cur;
        if (req && (lvl > cur.lvl)) begin
            res.lvl = lvl;
            res.vec = vec;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### sv/cpu_interrupt_priority_arbiter_core.sv
// Top level: interrupt priority arbiter, input register then result register.
// A request accepted by start is captured in the input register; its winner is then
// held in the result register and shown on win_level and win_vector with done high.
// Throughput: one request per cycle; busy is always low, two register stages.
// Reset: all configuration registers clear to zero, no result is pending.
// The result strobe lasts one cycle; the receiver cannot stall it.
`default_nettype none
module cpu_interrupt_priority_arbiter_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [4:0]                   external_pending,
    input  wire logic [1:0]                   divider_ctrl,
    input  wire logic [2:0]                   dma0_chan_ctrl,
    input  wire logic [2:0]                   dma1_chan_ctrl,
    input  wire logic [7:0]                   watchdog_status,
    input  wire logic [7:0]                   timer_status,
    input  wire logic [7:0]                   timer_enables,
    input  wire logic                         cfg_we,
    input  wire logic [cipa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cipa_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output logic                              done,
    output logic [3:0]                        win_level,
    output logic [6:0]                        win_vector
);
    import cipa_pkg::*;

    // Configuration registers, only the used bits are kept
    logic [3:0] ext_mask_reg;
    lvl_t       pri_div_reg;
    lvl_t       pri_dma_reg;
    lvl_t       pri_wdt_reg;
    lvl_t       pri_tmr_reg;
    vec_t       vec_div_reg;
    vec_t       vec_wdt_reg;
    vec_t       vec_cap_reg;
    vec_t       vec_cmp_reg;
    vec_t       vec_ovf_reg;
    vec_t       vec_dma0_reg;
    vec_t       vec_dma1_reg;

    // Pipeline registers
    in_item_t   item_reg;
    in_item_t   item_next;
    logic       item_valid_reg;
    winner_t    res_reg;
    winner_t    res_next;
    logic       res_valid_reg;

    logic       accept;
    logic [4:0] ext_act;
    lvl_t       ext_lvl;
    logic [7:0] tmr_fire;
    winner_t    w0, w1, w2, w3, w4, w5, w6, w7;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_mask_reg <= '0;
            pri_div_reg  <= '0;
            pri_dma_reg  <= '0;
            pri_wdt_reg  <= '0;
            pri_tmr_reg  <= '0;
            vec_div_reg  <= '0;
            vec_wdt_reg  <= '0;
            vec_cap_reg  <= '0;
            vec_cmp_reg  <= '0;
            vec_ovf_reg  <= '0;
            vec_dma0_reg <= '0;
            vec_dma1_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_EXT_MASK:    ext_mask_reg <= cfg_wdata[3:0];
                CFG_PRIORITY_A:
                begin
                    pri_div_reg <= cfg_wdata[15:12];
                    pri_dma_reg <= cfg_wdata[11:8];
                    pri_wdt_reg <= cfg_wdata[7:4];
                end
                CFG_TIMER_PRI:   pri_tmr_reg <= cfg_wdata[3:0];
                CFG_DIV_VEC:     vec_div_reg <= cfg_wdata[6:0];
                CFG_WDT_VEC:     vec_wdt_reg <= cfg_wdata[14:8];
                CFG_TIMER_VEC_C:
                begin
                    vec_cap_reg <= cfg_wdata[14:8];
                    vec_cmp_reg <= cfg_wdata[6:0];
                end
                CFG_TIMER_VEC_D: vec_ovf_reg <= cfg_wdata[14:8];
                CFG_DMA_VECS:
                begin
                    vec_dma0_reg <= cfg_wdata[6:0];
                    vec_dma1_reg <= cfg_wdata[13:7];
                end
                default: ;
            endcase
        end
    end

    // Input capture
    always_comb
    begin
        item_next.external_pending = external_pending;
        item_next.divider_ctrl     = divider_ctrl;
        item_next.dma0_chan_ctrl   = dma0_chan_ctrl;
        item_next.dma1_chan_ctrl   = dma1_chan_ctrl;
        item_next.watchdog_status  = watchdog_status;
        item_next.timer_status     = timer_status;
        item_next.timer_enables    = timer_enables;
    end

    // External sources: bit 4 is never masked
    assign ext_act = item_reg.external_pending & {1'b1, ext_mask_reg};

    always_comb
    begin
        if (ext_act[4])      ext_lvl = EXT_LVL_NMI;
        else if (ext_act[3]) ext_lvl = EXT_LVL_3;
        else if (ext_act[2]) ext_lvl = EXT_LVL_2;
        else if (ext_act[1]) ext_lvl = EXT_LVL_1;
        else if (ext_act[0]) ext_lvl = EXT_LVL_0;
        else                 ext_lvl = '0;
    end

    assign tmr_fire = item_reg.timer_status & item_reg.timer_enables;

    // Priority chain over on-chip sources, earlier source wins ties
    always_comb
    begin
        w0.lvl = ext_lvl;
        w0.vec = (ext_lvl != '0) ? (EXT_VEC_BASE + vec_t'(ext_lvl[LVL_W-1:1])) : '0;
        w1 = offer(w0, &item_reg.divider_ctrl, pri_div_reg, vec_div_reg);
        w2 = offer(w1, &item_reg.dma0_chan_ctrl[2:1], pri_dma_reg, vec_dma0_reg);
        w3 = offer(w2, &item_reg.dma1_chan_ctrl[2:1], pri_dma_reg, vec_dma1_reg);
        w4 = offer(w3, item_reg.watchdog_status[7:5] == WDT_REQ_PAT,
                   pri_wdt_reg, vec_wdt_reg);
        w5 = offer(w4, tmr_fire[TMR_CAP_BIT], pri_tmr_reg, vec_cap_reg);
        w6 = offer(w5, tmr_fire[TMR_CMPA_BIT] || tmr_fire[TMR_CMPB_BIT],
                   pri_tmr_reg, vec_cmp_reg);
        w7 = offer(w6, tmr_fire[TMR_OVF_BIT], pri_tmr_reg, vec_ovf_reg);
        res_next = w7;
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= accept;
            res_valid_reg  <= item_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
        if (item_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign done       = res_valid_reg;
    assign win_level  = res_reg.lvl;
    assign win_vector = res_reg.vec;

endmodule
`default_nettype wire

### bench/cpu_interrupt_priority_arbiter_core_test.sv
// Testbench for the interrupt priority arbiter: directed and random requests against a predictor.
`timescale 1ns / 1ps
module cpu_interrupt_priority_arbiter_core_test;
    import cipa_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 100;
    localparam int RANDOM_PHASES = 10;

    // Mirror of the configuration and queue of predicted winners
    class irq_scoreboard;
        logic [3:0]  ext_mask;
        logic [15:0] pri_a;
        lvl_t        tmr_pri;
        vec_t        div_vec;
        logic [15:0] wdt_word;
        logic [15:0] tmr_vec_c;
        logic [15:0] tmr_vec_d;
        logic [13:0] dma_vecs;
        winner_t     winners_q[$];
        int          errors;

        function new();
            ext_mask  = '0;
            pri_a     = '0;
            tmr_pri   = '0;
            div_vec   = '0;
            wdt_word  = '0;
            tmr_vec_c = '0;
            tmr_vec_d = '0;
            dma_vecs  = '0;
            errors    = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [15:0] d);
            case (idx)
                CFG_EXT_MASK:    ext_mask  = d[3:0];
                CFG_PRIORITY_A:  pri_a     = d;
                CFG_TIMER_PRI:   tmr_pri   = d[3:0];
                CFG_DIV_VEC:     div_vec   = d[6:0];
                CFG_WDT_VEC:     wdt_word  = d;
                CFG_TIMER_VEC_C: tmr_vec_c = d;
                CFG_TIMER_VEC_D: tmr_vec_d = d;
                CFG_DMA_VECS:    dma_vecs  = d[13:0];
                default: ;
            endcase
        endfunction

        // Winner for one request under the current configuration
        function winner_t arbitrate(in_item_t it);
            logic [4:0] gated;
            logic [7:0] fire;
            logic [6:0] req;
            lvl_t       lv [7];
            vec_t       vc [7];
            winner_t    w;
            gated = it.external_pending & {1'b1, ext_mask};
            w = '0;
            if (gated[4])      w.lvl = EXT_LVL_NMI;
            else if (gated[3]) w.lvl = EXT_LVL_3;
            else if (gated[2]) w.lvl = EXT_LVL_2;
            else if (gated[1]) w.lvl = EXT_LVL_1;
            else if (gated[0]) w.lvl = EXT_LVL_0;
            if (w.lvl != 0)
                w.vec = EXT_VEC_BASE + vec_t'(w.lvl >> 1);

            // on-chip sources in fixed order: divider, dma0, dma1, watchdog,
            // capture, compare, overflow
            fire = it.timer_status & it.timer_enables;
            req[0] = (it.divider_ctrl == 2'b11);
            req[1] = (it.dma0_chan_ctrl[2:1] == 2'b11);
            req[2] = (it.dma1_chan_ctrl[2:1] == 2'b11);
            req[3] = (it.watchdog_status[7:5] == WDT_REQ_PAT);
            req[4] = fire[TMR_CAP_BIT];
            req[5] = fire[TMR_CMPA_BIT] | fire[TMR_CMPB_BIT];
            req[6] = fire[TMR_OVF_BIT];
            lv[0] = pri_a[15:12];
            lv[1] = pri_a[11:8];
            lv[2] = pri_a[11:8];
            lv[3] = pri_a[7:4];
            lv[4] = tmr_pri;
            lv[5] = tmr_pri;
            lv[6] = tmr_pri;
            vc[0] = div_vec;
            vc[1] = dma_vecs[6:0];
            vc[2] = dma_vecs[13:7];
            vc[3] = wdt_word[14:8];
            vc[4] = tmr_vec_c[14:8];
            vc[5] = tmr_vec_c[6:0];
            vc[6] = tmr_vec_d[14:8];
            // strictly higher level replaces; ties keep the earlier source
            for (int i = 0; i < 7; i++)
            begin
                if (req[i] && (lv[i] > w.lvl))
                begin
                    w.lvl = lv[i];
                    w.vec = vc[i];
                end
            end
            return w;
        endfunction

        function void note_request(in_item_t it);
            winners_q.push_back(arbitrate(it));
        endfunction

        function void check_result(lvl_t lvl, vec_t vec);
            winner_t w;
            if (winners_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got level %0d vector %0d",
                         $time, lvl, vec);
                errors++;
                return;
            end
            w = winners_q.pop_front();
            if (lvl !== w.lvl)
            begin
                $display("%0t: win_level mismatch, expected %0d, got %0d",
                         $time, w.lvl, lvl);
                errors++;
            end
            if (vec !== w.vec)
            begin
                $display("%0t: win_vector mismatch, expected %0d, got %0d",
                         $time, w.vec, vec);
                errors++;
            end
        endfunction

        function int outstanding();
            return winners_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    in_item_t    req_item = '0;
    logic        cfg_we = 1'b0;
    cfg_idx_t    cfg_index = CFG_EXT_MASK;
    logic [15:0] cfg_wdata = '0;
    logic        busy;
    logic        done;
    logic [3:0]  win_level;
    logic [6:0]  win_vector;
    int          stall_cycles = 0;
    irq_scoreboard sb = new();

    cpu_interrupt_priority_arbiter_core DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .external_pending (req_item.external_pending),
        .divider_ctrl     (req_item.divider_ctrl),
        .dma0_chan_ctrl   (req_item.dma0_chan_ctrl),
        .dma1_chan_ctrl   (req_item.dma1_chan_ctrl),
        .watchdog_status  (req_item.watchdog_status),
        .timer_status     (req_item.timer_status),
        .timer_enables    (req_item.timer_enables),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .done             (done),
        .win_level        (win_level),
        .win_vector       (win_vector)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Monitor: check results, record accepted transfers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(win_level, win_vector);
            if (start && !busy)
                sb.note_request(req_item);
        end
    end

    // Watchdog on cycles with no transfer and no result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles = 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            stall_cycles++;
    end

    function automatic in_item_t make_item(logic [4:0] pend, logic [1:0] divc,
                                           logic [2:0] d0, logic [2:0] d1,
                                           logic [7:0] wdt, logic [7:0] ts,
                                           logic [7:0] te);
        in_item_t it;
        it.external_pending = pend;
        it.divider_ctrl     = divc;
        it.dma0_chan_ctrl   = d0;
        it.dma1_chan_ctrl   = d1;
        it.watchdog_status  = wdt;
        it.timer_status     = ts;
        it.timer_enables    = te;
        return it;
    endfunction

    // Random request, biased so on-chip sources often get past the externals
    function automatic in_item_t random_item();
        in_item_t it;
        it.external_pending = ($urandom_range(0, 2) == 0) ? 5'($urandom) : 5'($urandom & 5'h0F);
        if ($urandom_range(0, 1) == 0)
            it.external_pending = '0;
        it.divider_ctrl    = 2'($urandom);
        it.dma0_chan_ctrl  = 3'($urandom);
        it.dma1_chan_ctrl  = 3'($urandom);
        it.watchdog_status = ($urandom_range(0, 1) == 0) ? {WDT_REQ_PAT, 5'($urandom)}
                                                          : 8'($urandom);
        it.timer_status    = 8'($urandom);
        it.timer_enables   = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
        return it;
    endfunction

    function automatic logic [15:0] random_reg_value();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // One transfer; start stays high for back-to-back items
    task automatic send_item(in_item_t it);
        start <= 1'b1;
        req_item <= it;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic idle(int cycles);
        repeat (cycles)
        begin
            start <= 1'b0;
            req_item <= random_item();
            @(posedge clk);
        end
    endtask

    // Wait until every predicted result has arrived
    task automatic drain();
        start <= 1'b0;
        while (sb.outstanding() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all registers in index order, one per cycle
    task automatic write_regs(logic [15:0] mask, logic [15:0] pa, logic [15:0] tp,
                              logic [15:0] dv, logic [15:0] wv, logic [15:0] tc,
                              logic [15:0] td, logic [15:0] dm);
        logic [15:0] vals [8];
        cfg_idx_t    idx;
        vals[0] = mask;
        vals[1] = pa;
        vals[2] = tp;
        vals[3] = dv;
        vals[4] = wv;
        vals[5] = tc;
        vals[6] = td;
        vals[7] = dm;
        idx = idx.first();
        for (int i = 0; i < 8; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= vals[i];
            @(posedge clk);
            sb.set_reg(idx, vals[i]);
            idx = idx.next();
        end
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase();
        int left;
        int burst;
        write_regs(random_reg_value(), random_reg_value(), random_reg_value(),
                   random_reg_value(), random_reg_value(), random_reg_value(),
                   random_reg_value(), random_reg_value());
        left = PHASE_ITEMS;
        while (left > 0)
        begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst && left > 0; i++)
            begin
                send_item(random_item());
                left--;
            end
            if ($urandom_range(0, 3) != 0)
                idle($urandom_range(1, 8));
        end
        drain();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: on-chip sources at level zero never win
        send_item(make_item(5'h00, 2'd0, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00));
        send_item(make_item(5'h1F, 2'd3, 3'd7, 3'd7, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_item(5'h0F, 2'd3, 3'd6, 3'd6, 8'hA0, 8'h8E, 8'hFF));
        drain();

        // All registers at their maximum
        write_regs(16'h000F, 16'hFFFF, 16'h000F, 16'h007F,
                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h3FFF);
        send_item(make_item(5'h1F, 2'd3, 3'd7, 3'd7, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_item(5'h01, 2'd0, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00));
        send_item(make_item(5'h02, 2'd0, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00));
        send_item(make_item(5'h04, 2'd0, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00));
        send_item(make_item(5'h08, 2'd0, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00));
        drain();

        // Distinct levels per priority field and distinct vectors per source
        write_regs(16'h0005, 16'h3A7F, 16'h000B, 16'h0011,
                   16'h2200, 16'h3344, 16'h5500, 16'h3377);
        send_item(make_item(5'h00, 2'd3, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00));
        send_item(make_item(5'h00, 2'd2, 3'd3, 3'd0, 8'h00, 8'h00, 8'h00));
        send_item(make_item(5'h00, 2'd0, 3'd6, 3'd0, 8'h00, 8'h00, 8'h00));
        send_item(make_item(5'h00, 2'd0, 3'd0, 3'd7, 8'h00, 8'h00, 8'h00));
        send_item(make_item(5'h00, 2'd0, 3'd6, 3'd6, 8'h00, 8'h00, 8'h00));
        send_item(make_item(5'h00, 2'd0, 3'd0, 3'd0, 8'hA0, 8'h00, 8'h00));
        send_item(make_item(5'h00, 2'd0, 3'd0, 3'd0, 8'hE0, 8'h00, 8'h00));
        send_item(make_item(5'h00, 2'd0, 3'd0, 3'd0, 8'hBF, 8'h80, 8'h80));
        send_item(make_item(5'h00, 2'd0, 3'd0, 3'd0, 8'h00, 8'h08, 8'h08));
        send_item(make_item(5'h00, 2'd0, 3'd0, 3'd0, 8'h00, 8'h04, 8'h04));
        send_item(make_item(5'h00, 2'd0, 3'd0, 3'd0, 8'h00, 8'hFF, 8'h00));
        send_item(make_item(5'h00, 2'd0, 3'd0, 3'd0, 8'h00, 8'h02, 8'h02));
        send_item(make_item(5'h05, 2'd0, 3'd0, 3'd0, 8'h00, 8'hFF, 8'hFF));
        send_item(make_item(5'h0A, 2'd0, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00));
        drain();

        // Random configurations, bursty stimulus
        for (int p = 0; p < RANDOM_PHASES; p++)
            random_phase();

        if (sb.outstanding() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, sb.outstanding());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
